/* src/mmm_pkg.sv */
// ----------------------------------------------------------------------------
// mmm_pkg: shared types and constants for the montgomery modular multiplier
// Register indexes, port widths and register reset values.
// ----------------------------------------------------------------------------
package mmm_pkg;

   // width of every field on the ports
   localparam int IO_WIDTH        = 16;
   localparam int REQ_DATA_WIDTH  = 2 * IO_WIDTH;
   localparam int RSP_DATA_WIDTH  = IO_WIDTH;
   localparam int CSR_INDEX_WIDTH = 1;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODULUS     = 1'b0,
      CSR_NEG_INVERSE = 1'b1
   } csr_index_type;

   // register reset values (the inverse matches the modulus)
   localparam logic [IO_WIDTH-1:0] MODULUS_RESET     = 16'd65521;
   localparam logic [IO_WIDTH-1:0] NEG_INVERSE_RESET = 16'd61167;

endpackage

/* src/montgomery_modular_multiply.sv */
// ----------------------------------------------------------------------------
// montgomery_modular_multiply: (a * b) mod n through the montgomery domain
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  multiplicand, multiplier
//   rsp      out        rsp_tvalid/rsp_tready  product_mod
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle sustained while rsp_tready is held high, through the remainder
// pipeline (WORD_WIDTH stages), the multiply stage and two four-stage reductions.
// Synchronous reset empties every stage and loads the register reset values.
// Each stage loads when empty or when the next moves, so bubbles close up
// under rsp backpressure; csr writes are taken in any cycle.
// ----------------------------------------------------------------------------
module montgomery_modular_multiply #(
   parameter int WORD_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // tdata: multiplicand [15:0], multiplier [31:16]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mmm_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   // tdata: product_mod [15:0]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mmm_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mmm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mmm_pkg::IO_WIDTH-1:0]          csr_data
);

   import mmm_pkg::*;

   localparam int W = WORD_WIDTH;

   logic [IO_WIDTH-1:0] modulus_ff;
   logic [IO_WIDTH-1:0] neg_inverse_ff;

   logic [W-1:0]   n_w;
   logic [W-1:0]   ninv_w;
   logic [W-1:0]   a_w;
   logic [W-1:0]   b_w;

   logic           mont_valid;
   logic           mont_ready;
   logic [W-1:0]   mont_a;
   logic [W-1:0]   mont_b;
   logic           prod_valid;
   logic           prod_ready;
   logic [2*W-1:0] prod;
   logic           red1_valid;
   logic           red1_ready;
   logic [W-1:0]   red1;
   logic [W-1:0]   red2;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= MODULUS_RESET;
         neg_inverse_ff <= NEG_INVERSE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODULUS:     modulus_ff     <= csr_data;
            CSR_NEG_INVERSE: neg_inverse_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // fit registers and operands to the word
   assign n_w    = W'(modulus_ff);
   assign ninv_w = W'(neg_inverse_ff);
   assign a_w    = W'(req_tdata[IO_WIDTH-1:0]);
   assign b_w    = W'(req_tdata[2*IO_WIDTH-1:IO_WIDTH]);

   mmm_to_mont #(
      .WORD_WIDTH (W)
   ) u_to_mont (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_a      (a_w),
      .in_b      (b_w),
      .modulus   (n_w),
      .out_valid (mont_valid),
      .out_ready (mont_ready),
      .out_a     (mont_a),
      .out_b     (mont_b)
   );

   mmm_mult #(
      .WORD_WIDTH (W)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mont_valid),
      .in_ready  (mont_ready),
      .in_a      (mont_a),
      .in_b      (mont_b),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_p     (prod)
   );

   mmm_reduce #(
      .WORD_WIDTH (W)
   ) u_reduce_1 (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (prod_valid),
      .in_ready    (prod_ready),
      .in_t        (prod),
      .modulus     (n_w),
      .neg_inverse (ninv_w),
      .out_valid   (red1_valid),
      .out_ready   (red1_ready),
      .out_r       (red1)
   );

   // second reduction leaves the montgomery domain
   mmm_reduce #(
      .WORD_WIDTH (W)
   ) u_reduce_2 (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (red1_valid),
      .in_ready    (red1_ready),
      .in_t        ({{W{1'b0}}, red1}),
      .modulus     (n_w),
      .neg_inverse (ninv_w),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_r       (red2)
   );

   // zero modulus gives zero
   assign rsp_tdata = (n_w == '0) ? '0 : RSP_DATA_WIDTH'(red2);

endmodule

/* src/mmm_to_mont.sv */
// ----------------------------------------------------------------------------
// mmm_to_mont: map both operands into the montgomery domain
// Computes (x * 2^W) mod n for two operands with a restoring remainder
// pipeline, two shift-and-subtract steps per stage, W stages in all.
// ----------------------------------------------------------------------------
module mmm_to_mont #(
   parameter int WORD_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [WORD_WIDTH-1:0] in_a,
   input  logic [WORD_WIDTH-1:0] in_b,
   input  logic [WORD_WIDTH-1:0] modulus,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [WORD_WIDTH-1:0] out_a,
   output logic [WORD_WIDTH-1:0] out_b
);

   localparam int W      = WORD_WIDTH;
   localparam int NSTAGE = WORD_WIDTH;

   // one restoring step: shift in a dividend bit, subtract n if it fits
   function automatic logic [W-1:0] div_step(input logic [W-1:0] rem,
                                             input logic         din,
                                             input logic [W-1:0] dvsr);
      logic [W:0] t;
      begin
         t = {rem, din};
         if (t >= {1'b0, dvsr}) begin
            t = t - {1'b0, dvsr};
         end
         return t[W-1:0];
      end
   endfunction

   logic         valid_ff [NSTAGE];
   logic [W-1:0] ra_ff    [NSTAGE];
   logic [W-1:0] rb_ff    [NSTAGE];
   logic [W-1:0] sa_ff    [NSTAGE];
   logic [W-1:0] sb_ff    [NSTAGE];
   logic         ready    [NSTAGE+1];

   assign ready[NSTAGE] = out_ready;
   assign in_ready      = ready[0];

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      logic         v_prev;
      logic [W-1:0] ra_prev;
      logic [W-1:0] rb_prev;
      logic [W-1:0] sa_prev;
      logic [W-1:0] sb_prev;
      logic [W-1:0] ra_mid;
      logic [W-1:0] rb_mid;
      logic [W-1:0] ra_in;
      logic [W-1:0] rb_in;
      logic [W-1:0] sa_in;
      logic [W-1:0] sb_in;

      // stage input: the request for the first stage, the previous stage after
      if (s == 0) begin : g_first
         assign v_prev  = in_valid;
         assign ra_prev = '0;
         assign rb_prev = '0;
         assign sa_prev = in_a;
         assign sb_prev = in_b;
      end else begin : g_next
         assign v_prev  = valid_ff[s-1];
         assign ra_prev = ra_ff[s-1];
         assign rb_prev = rb_ff[s-1];
         assign sa_prev = sa_ff[s-1];
         assign sb_prev = sb_ff[s-1];
      end

      // two dividend bits per stage, operand msb first, then zeros
      always_comb begin
         ra_mid = div_step(ra_prev, sa_prev[W-1], modulus);
         rb_mid = div_step(rb_prev, sb_prev[W-1], modulus);
         ra_in  = div_step(ra_mid, sa_prev[W-2], modulus);
         rb_in  = div_step(rb_mid, sb_prev[W-2], modulus);
         sa_in  = {sa_prev[W-3:0], 2'b00};
         sb_in  = {sb_prev[W-3:0], 2'b00};
      end

      // stage loads when empty or when the next stage takes its item
      assign ready[s] = !valid_ff[s] || ready[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ready[s]) begin
            valid_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[s] && v_prev) begin
            ra_ff[s] <= ra_in;
            rb_ff[s] <= rb_in;
            sa_ff[s] <= sa_in;
            sb_ff[s] <= sb_in;
         end
      end
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_a     = ra_ff[NSTAGE-1];
   assign out_b     = rb_ff[NSTAGE-1];

endmodule

/* src/mmm_mult.sv */
// ----------------------------------------------------------------------------
// mmm_mult: product of the two mapped operands
// One registered W x W multiply stage with its own handshake.
// ----------------------------------------------------------------------------
module mmm_mult #(
   parameter int WORD_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [WORD_WIDTH-1:0]   in_a,
   input  logic [WORD_WIDTH-1:0]   in_b,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [2*WORD_WIDTH-1:0] out_p
);

   logic                    valid_ff;
   logic [2*WORD_WIDTH-1:0] prod_ff;
   logic [2*WORD_WIDTH-1:0] prod_in;

   // full width product
   assign prod_in  = {{WORD_WIDTH{1'b0}}, in_a} * {{WORD_WIDTH{1'b0}}, in_b};
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_p     = prod_ff;

endmodule

/* src/mmm_reduce.sv */
// ----------------------------------------------------------------------------
// mmm_reduce: one montgomery reduction
// Four stages: q = (T mod R) * n' mod R, q * n, (T + q * n) / R, and one
// conditional subtraction of n.
// ----------------------------------------------------------------------------
module mmm_reduce #(
   parameter int WORD_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [2*WORD_WIDTH-1:0] in_t,
   input  logic [WORD_WIDTH-1:0]   modulus,
   input  logic [WORD_WIDTH-1:0]   neg_inverse,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [WORD_WIDTH-1:0]   out_r
);

   localparam int W      = WORD_WIDTH;
   localparam int NSTAGE = 4;

   logic           valid_ff [NSTAGE];
   logic           ready    [NSTAGE+1];

   logic [2*W-1:0] t1_ff;
   logic [W-1:0]   q_ff;
   logic [2*W-1:0] t2_ff;
   logic [2*W-1:0] qn_ff;
   logic [W:0]     res_ff;
   logic [W-1:0]   out_ff;

   logic [2*W-1:0] lo_prod;
   logic [W-1:0]   q_in;
   logic [2*W-1:0] qn_in;
   logic [2*W:0]   sum;
   logic [W:0]     res_in;
   logic [W-1:0]   out_in;

   // datapath of the four stages
   always_comb begin
      lo_prod = {{W{1'b0}}, in_t[W-1:0]} * {{W{1'b0}}, neg_inverse};
      q_in    = lo_prod[W-1:0];
      qn_in   = {{W{1'b0}}, q_ff} * {{W{1'b0}}, modulus};
      sum     = {1'b0, t2_ff} + {1'b0, qn_ff};
      res_in  = sum[2*W:W];
      if (res_ff >= {1'b0, modulus}) begin
         out_in = W'(res_ff - {1'b0, modulus});
      end else begin
         out_in = res_ff[W-1:0];
      end
   end

   // per stage valid and backpressure
   assign ready[NSTAGE] = out_ready;
   for (genvar s = 0; s < NSTAGE; s++) begin : g_ctrl
      logic v_prev;
      if (s == 0) begin : g_first
         assign v_prev = in_valid;
      end else begin : g_next
         assign v_prev = valid_ff[s-1];
      end

      assign ready[s] = !valid_ff[s] || ready[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ready[s]) begin
            valid_ff[s] <= v_prev;
         end
      end
   end

   // stage payload registers
   always_ff @(posedge clock) begin
      if (ready[0] && in_valid) begin
         t1_ff <= in_t;
         q_ff  <= q_in;
      end
      if (ready[1] && valid_ff[0]) begin
         t2_ff <= t1_ff;
         qn_ff <= qn_in;
      end
      if (ready[2] && valid_ff[1]) begin
         res_ff <= res_in;
      end
      if (ready[3] && valid_ff[2]) begin
         out_ff <= out_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NSTAGE-1];
   assign out_r     = out_ff;

endmodule
